// File: src/llqm_pkg.sv
package llqm_pkg;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_LINK,
      ST_RESP
   } llqm_state_type;

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_QUEUED    = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [1:0] STATUS_NOT_OWNED = 2'd3;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic exec;
      logic link;
      logic load_rsp;
   } llqm_ctrl_type;

   typedef struct packed {
      logic clear_last;
      logic need_link;
      logic rsp_free;
   } llqm_stat_type;

endpackage

// File: src/linked_list_queue_manager_top.sv
// Flow: an accepted request reads the single-port next/prev/owner link memories, writes
// them back in the exec step (and, for append to a non-empty queue, the link step), then
// loads rsp; one request is handled at a time, and the next is taken as rsp is loaded.
// Reset: synchronous, active high; afterwards a clearing pass over all NUM_ELEMENTS
// elements marks every element not queued, and req_ready stays low until it ends.
module linked_list_queue_manager_top
   import llqm_pkg::*;
#(
   parameter int NUM_ELEMENTS = 64,
   parameter int NUM_QUEUES   = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [1:0] req_queue_id,
   input  logic [5:0] req_element,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [6:0] rsp_count,
   output logic [5:0] rsp_head_element,
   output logic       rsp_queue_empty
);

   llqm_ctrl_type ctrl;
   llqm_stat_type stat;

   llqm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   llqm_dp #(
      .NUM_ELEMENTS (NUM_ELEMENTS),
      .NUM_QUEUES   (NUM_QUEUES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_command      (req_command),
      .req_queue_id     (req_queue_id),
      .req_element      (req_element),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_count        (rsp_count),
      .rsp_head_element (rsp_head_element),
      .rsp_queue_empty  (rsp_queue_empty)
   );

endmodule

// File: src/llqm_ctrl.sv
module llqm_ctrl
   import llqm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  llqm_stat_type stat,
   output llqm_ctrl_type ctrl
);

   llqm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctrl.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.accept = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctrl.exec = 1'b1;
            state_in  = stat.need_link ? ST_LINK : ST_RESP;
         end
         ST_LINK: begin
            ctrl.link = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (stat.rsp_free) begin
               ctrl.load_rsp = 1'b1;
               req_ready     = 1'b1;
               if (req_valid) begin
                  ctrl.accept = 1'b1;
                  state_in    = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

// File: src/llqm_dp.sv
module llqm_dp
   import llqm_pkg::*;
#(
   parameter int NUM_ELEMENTS = 64,
   parameter int NUM_QUEUES   = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  llqm_ctrl_type ctrl,
   output llqm_stat_type stat,
   input  logic [1:0]    req_command,
   input  logic [1:0]    req_queue_id,
   input  logic [5:0]    req_element,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output logic [1:0]    rsp_status,
   output logic [6:0]    rsp_count,
   output logic [5:0]    rsp_head_element,
   output logic          rsp_queue_empty
);

   localparam int EW = $clog2(NUM_ELEMENTS);
   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int CW = $clog2(NUM_ELEMENTS + 1);

   typedef struct packed {
      logic          valid;
      logic [QW-1:0] queue;
   } owner_type;

   logic [EW-1:0] next_mem  [NUM_ELEMENTS];
   logic [EW-1:0] prev_mem  [NUM_ELEMENTS];
   owner_type     owner_mem [NUM_ELEMENTS];

   logic [EW-1:0] head_ff  [NUM_QUEUES];
   logic [CW-1:0] count_ff [NUM_QUEUES];

   logic [EW-1:0] clr_ff;

   logic [1:0]    cmd_ff;
   logic [QW-1:0] q_ff;
   logic          q_ok_ff;
   logic [EW-1:0] e_ff;
   logic          e_ok_ff;
   logic [EW-1:0] next_rd_ff;
   logic [EW-1:0] prev_rd_ff;
   owner_type     owner_rd_ff;
   logic [1:0]    status_ff;
   logic [1:0]    status_in;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [6:0]    rsp_count_ff;
   logic [5:0]    rsp_head_ff;
   logic          rsp_empty_ff;

   logic [15:0]   elem_wide;
   logic [7:0]    q_wide;
   logic [EW-1:0] e_idx_in;
   logic [QW-1:0] q_idx_in;
   logic          e_ok_in;
   logic          q_ok_in;
   logic [EW-1:0] prev_addr;

   logic [CW-1:0] cur_cnt;
   logic [EW-1:0] cur_head;
   logic          cnt_zero;
   logic          cnt_one;
   logic          do_app;
   logic          do_rem;

   logic          next_we, prev_we, owner_we;
   logic [EW-1:0] next_wa, next_wd, prev_wa, prev_wd, owner_wa;
   owner_type     owner_wd;

   logic [CW-1:0] rsp_cnt_sel;
   logic          rsp_empty_sel;
   logic [EW-1:0] rsp_head_sel;

   assign elem_wide = 16'(req_element);
   assign q_wide    = 8'(req_queue_id);
   assign e_idx_in  = elem_wide[EW-1:0];
   assign q_idx_in  = q_wide[QW-1:0];
   assign e_ok_in   = elem_wide < 16'(NUM_ELEMENTS);
   assign q_ok_in   = q_wide < 8'(NUM_QUEUES);
   assign prev_addr = (req_command == CMD_APPEND) ? head_ff[q_idx_in] : e_idx_in;

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         cmd_ff      <= req_command;
         q_ff        <= q_idx_in;
         q_ok_ff     <= q_ok_in;
         e_ff        <= e_idx_in;
         e_ok_ff     <= e_ok_in;
         next_rd_ff  <= next_mem[e_idx_in];
         prev_rd_ff  <= prev_mem[prev_addr];
         owner_rd_ff <= owner_mem[e_idx_in];
      end
   end

   assign cur_cnt  = count_ff[q_ff];
   assign cur_head = head_ff[q_ff];
   assign cnt_zero = cur_cnt == '0;
   assign cnt_one  = cur_cnt == CW'(1);

   always_comb begin
      status_in = STATUS_OK;
      do_app    = 1'b0;
      do_rem    = 1'b0;
      case (cmd_ff)
         CMD_APPEND: begin
            if (!q_ok_ff || !e_ok_ff) begin
               status_in = STATUS_NOT_OWNED;
            end else if (owner_rd_ff.valid) begin
               status_in = STATUS_QUEUED;
            end else begin
               do_app = 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (!q_ok_ff) begin
               status_in = STATUS_NOT_OWNED;
            end else if (cnt_zero) begin
               status_in = STATUS_EMPTY;
            end else if (!e_ok_ff || !owner_rd_ff.valid || owner_rd_ff.queue != q_ff) begin
               status_in = STATUS_NOT_OWNED;
            end else begin
               do_rem = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign stat.need_link  = do_app && !cnt_zero;
   assign stat.clear_last = clr_ff == EW'(NUM_ELEMENTS - 1);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   // append to non-empty: tail/head links now, new element's own links in link step
   always_comb begin
      next_we  = 1'b0;
      next_wa  = e_ff;
      next_wd  = e_ff;
      prev_we  = 1'b0;
      prev_wa  = e_ff;
      prev_wd  = e_ff;
      owner_we = 1'b0;
      owner_wa = e_ff;
      owner_wd = '0;
      if (ctrl.clear_step) begin
         owner_we = 1'b1;
         owner_wa = clr_ff;
      end else if (ctrl.exec) begin
         if (do_app) begin
            owner_we = 1'b1;
            owner_wd = '{valid: 1'b1, queue: q_ff};
            next_we  = 1'b1;
            prev_we  = 1'b1;
            if (!cnt_zero) begin
               next_wa = prev_rd_ff;
               prev_wa = cur_head;
            end
         end else if (do_rem) begin
            owner_we = 1'b1;
            if (!cnt_one) begin
               next_we = 1'b1;
               next_wa = prev_rd_ff;
               next_wd = next_rd_ff;
               prev_we = 1'b1;
               prev_wa = next_rd_ff;
               prev_wd = prev_rd_ff;
            end
         end
      end else if (ctrl.link) begin
         next_we = 1'b1;
         next_wd = cur_head;
         prev_we = 1'b1;
         prev_wd = prev_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (owner_we) begin
         owner_mem[owner_wa] <= owner_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (ctrl.clear_step) begin
         clr_ff <= clr_ff + EW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            count_ff[i] <= '0;
         end
      end else if (ctrl.exec) begin
         if (do_app) begin
            count_ff[q_ff] <= cur_cnt + CW'(1);
         end else if (do_rem) begin
            count_ff[q_ff] <= cur_cnt - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         status_ff <= status_in;
         if (do_app && cnt_zero) begin
            head_ff[q_ff] <= e_ff;
         end else if (do_rem && !cnt_one && cur_head == e_ff) begin
            head_ff[q_ff] <= next_rd_ff;
         end
      end
   end

   assign rsp_cnt_sel   = q_ok_ff ? cur_cnt : '0;
   assign rsp_empty_sel = rsp_cnt_sel == '0;
   assign rsp_head_sel  = rsp_empty_sel ? '0 : cur_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= 7'(rsp_cnt_sel);
         rsp_head_ff   <= 6'(rsp_head_sel);
         rsp_empty_ff  <= rsp_empty_sel;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_count        = rsp_count_ff;
   assign rsp_head_element = rsp_head_ff;
   assign rsp_queue_empty  = rsp_empty_ff;

endmodule

// File: src/llqm_checker.sv
module llqm_checker
   import llqm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_command,
   input logic [1:0] req_queue_id,
   input logic [5:0] req_element,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [6:0] rsp_count,
   input logic [5:0] rsp_head_element,
   input logic       rsp_queue_empty
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count)
         && $stable(rsp_head_element) && $stable(rsp_queue_empty))
      else $error("rsp dropped or changed while stalled");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_queue_empty == (rsp_count == 7'd0)))
      else $error("queue_empty disagrees with count");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_queue_empty && rsp_head_element == 6'd0)
      else $error("empty status on a non-empty queue");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high during clearing pass");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transfer taken while busy");

endmodule

bind linked_list_queue_manager_top llqm_checker u_chk (.*);

// File: tb/testbench.sv
module testbench
   import llqm_pkg::*;
;

   localparam int NE = 64;
   localparam int NQ = 4;
   localparam int STALL_LIMIT = 3000;
   localparam int RANDOM_ITEMS = 1800;
   localparam int SEGMENT_LEN = 150;
   localparam logic [1:0] CMD_SIZE     = 2'd2;
   localparam logic [1:0] CMD_SIZE_ALT = 2'd3;

   typedef struct packed {
      logic [1:0] command;
      logic [1:0] queue_id;
      logic [5:0] element;
   } queue_cmd_type;

   typedef struct packed {
      logic [1:0] status;
      logic [6:0] count;
      logic [5:0] head_element;
      logic       queue_empty;
   } queue_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_command = '0;
   logic [1:0] req_queue_id = '0;
   logic [5:0] req_element = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [6:0] rsp_count;
   logic [5:0] rsp_head_element;
   logic       rsp_queue_empty;

   linked_list_queue_manager_top #(
      .NUM_ELEMENTS(NE),
      .NUM_QUEUES(NQ)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_queue_id(req_queue_id),
      .req_element(req_element),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count),
      .rsp_head_element(rsp_head_element),
      .rsp_queue_empty(rsp_queue_empty)
   );

   queue_cmd_type pending_cmds[$];
   queue_rsp_type expected_rsps[$];
   int         total_items = 0;
   int         error_count = 0;
   int         stall_cycles = 0;
   logic       req_taken = 1'b0;

   // predicted block state
   logic [5:0] link_next[NE];
   logic [5:0] link_prev[NE];
   logic       elem_queued[NE];
   logic [1:0] elem_owner[NE];
   logic [5:0] q_head[NQ];
   logic [6:0] q_count[NQ];

   // stimulus-side ownership shadow
   logic       gen_queued[NE];
   logic [1:0] gen_owner[NE];

   initial begin
      for (int i = 0; i < NE; i++) begin
         link_next[i] = '0;
         link_prev[i] = '0;
         elem_queued[i] = 1'b0;
         elem_owner[i] = '0;
         gen_queued[i] = 1'b0;
         gen_owner[i] = '0;
      end
      for (int i = 0; i < NQ; i++) begin
         q_head[i] = '0;
         q_count[i] = '0;
      end
   end

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic queue_rsp_type apply_queue_cmd(queue_cmd_type c);
      queue_rsp_type r;
      logic [1:0] q;
      logic [5:0] e;
      logic [5:0] h;
      logic [5:0] t;
      logic [5:0] n;
      logic [5:0] p;
      q = c.queue_id;
      e = c.element;
      r.status = STATUS_OK;
      r.count = '0;
      r.head_element = '0;
      r.queue_empty = 1'b1;
      if (q >= NQ) begin
         if (c.command == CMD_APPEND || c.command == CMD_REMOVE) begin
            r.status = STATUS_NOT_OWNED;
         end
         return r;
      end
      if (c.command == CMD_APPEND) begin
         if (e >= NE) begin
            r.status = STATUS_NOT_OWNED;
         end else if (elem_queued[e]) begin
            r.status = STATUS_QUEUED;
         end else begin
            if (q_count[q] == 0) begin
               q_head[q] = e;
               link_next[e] = e;
               link_prev[e] = e;
            end else begin
               h = q_head[q];
               t = link_prev[h];
               link_next[t] = e;
               link_prev[e] = t;
               link_next[e] = h;
               link_prev[h] = e;
            end
            elem_queued[e] = 1'b1;
            elem_owner[e] = q;
            q_count[q] = q_count[q] + 7'd1;
         end
      end else if (c.command == CMD_REMOVE) begin
         if (q_count[q] == 0) begin
            r.status = STATUS_EMPTY;
         end else if (e >= NE || !elem_queued[e] || elem_owner[e] != q) begin
            r.status = STATUS_NOT_OWNED;
         end else begin
            if (q_count[q] == 1) begin
               q_head[q] = '0;
            end else begin
               n = link_next[e];
               p = link_prev[e];
               if (q_head[q] == e) begin
                  q_head[q] = n;
               end
               link_next[p] = n;
               link_prev[n] = p;
            end
            link_next[e] = '0;
            link_prev[e] = '0;
            elem_queued[e] = 1'b0;
            q_count[q] = q_count[q] - 7'd1;
         end
      end
      r.count = q_count[q];
      if (r.count != 0) begin
         r.head_element = q_head[q];
      end
      r.queue_empty = (r.count == 0);
      return r;
   endfunction

   task automatic add_item(logic [1:0] cmd, logic [1:0] q, logic [5:0] e);
      queue_cmd_type c;
      c.command = cmd;
      c.queue_id = q;
      c.element = e;
      pending_cmds.push_back(c);
      if (cmd == CMD_APPEND && !gen_queued[e]) begin
         gen_queued[e] = 1'b1;
         gen_owner[e] = q;
      end else if (cmd == CMD_REMOVE && gen_queued[e] && gen_owner[e] == q) begin
         gen_queued[e] = 1'b0;
      end
   endtask

   function automatic int pick_element(logic want_queued);
      int hits[$];
      for (int i = 0; i < NE; i++) begin
         if (gen_queued[i] == want_queued) begin
            hits.push_back(i);
         end
      end
      if (hits.size() == 0) begin
         return -1;
      end
      return hits[$urandom_range(hits.size() - 1)];
   endfunction

   function automatic logic [1:0] size_cmd();
      return $urandom_range(1) ? CMD_SIZE_ALT : CMD_SIZE;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // driver
   always @(negedge clock) begin
      static int sent_count = 0;
      int         phase;
      int         send_idle;
      int         recv_idle;
      queue_cmd_type c;
      if (!reset) begin
         phase = (total_items > 0) ? (sent_count * 3) / total_items : 2;
         case (phase)
            0: begin
               send_idle = 36;
               recv_idle = 48;
            end
            1: begin
               send_idle = 48;
               recv_idle = 36;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         rsp_ready <= ($urandom_range(99) >= recv_idle);
         if (!req_valid || req_taken) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle) begin
               c = pending_cmds.pop_front();
               req_command <= c.command;
               req_queue_id <= c.queue_id;
               req_element <= c.element;
               req_valid <= 1'b1;
               sent_count++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      queue_cmd_type seen;
      queue_rsp_type want;
      req_taken <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         seen.command = req_command;
         seen.queue_id = req_queue_id;
         seen.element = req_element;
         expected_rsps.push_back(apply_queue_cmd(seen));
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected transfer, status", rsp_status, -1);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_status !== want.status) begin
               report_mismatch("status", rsp_status, want.status);
            end
            if (rsp_count !== want.count) begin
               report_mismatch("count", rsp_count, want.count);
            end
            if (rsp_head_element !== want.head_element) begin
               report_mismatch("head_element", rsp_head_element, want.head_element);
            end
            if (rsp_queue_empty !== want.queue_empty) begin
               report_mismatch("queue_empty", rsp_queue_empty, want.queue_empty);
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [1:0] hot;
      int         roll;
      int         e;
      logic       fill_mode;

      // directed
      add_item(CMD_SIZE, 2'd0, 6'd0);
      add_item(CMD_REMOVE, 2'd0, 6'd5);
      add_item(CMD_APPEND, 2'd0, 6'd0);
      add_item(CMD_APPEND, 2'd0, 6'd63);
      add_item(CMD_APPEND, 2'd0, 6'd21);
      add_item(CMD_APPEND, 2'd1, 6'd63);
      add_item(CMD_REMOVE, 2'd1, 6'd0);
      add_item(CMD_APPEND, 2'd1, 6'd42);
      add_item(CMD_REMOVE, 2'd1, 6'd21);
      add_item(CMD_REMOVE, 2'd0, 6'd0);
      add_item(CMD_SIZE_ALT, 2'd0, 6'd63);
      add_item(CMD_REMOVE, 2'd0, 6'd63);
      add_item(CMD_REMOVE, 2'd0, 6'd21);
      add_item(CMD_REMOVE, 2'd1, 6'd42);
      add_item(CMD_APPEND, 2'd3, 6'd63);
      add_item(CMD_APPEND, 2'd3, 6'd0);
      add_item(CMD_APPEND, 2'd3, 6'd42);
      add_item(CMD_REMOVE, 2'd3, 6'd0);
      add_item(CMD_SIZE, 2'd3, 6'd21);
      add_item(CMD_APPEND, 2'd2, 6'd21);
      add_item(CMD_REMOVE, 2'd2, 6'd63);
      add_item(CMD_REMOVE, 2'd3, 6'd42);
      add_item(CMD_REMOVE, 2'd3, 6'd63);
      add_item(CMD_SIZE_ALT, 2'd2, 6'd42);

      // random: alternating fill-heavy and drain-heavy segments
      hot = '0;
      fill_mode = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % SEGMENT_LEN == 0) begin
            hot = 2'($urandom_range(NQ - 1));
            fill_mode = ((i / SEGMENT_LEN) % 2 == 0);
         end
         roll = $urandom_range(99);
         if (roll < 65) begin
            e = pick_element(!fill_mode);
            if (e < 0) begin
               e = $urandom_range(NE - 1);
            end
            if (fill_mode) begin
               add_item(CMD_APPEND, hot, 6'(e));
            end else begin
               add_item(CMD_REMOVE, gen_queued[e] ? gen_owner[e] : hot, 6'(e));
            end
         end else if (roll < 80) begin
            e = pick_element(fill_mode);
            if (e < 0) begin
               e = $urandom_range(NE - 1);
            end
            if (fill_mode) begin
               add_item(CMD_REMOVE, gen_queued[e] ? gen_owner[e] : hot, 6'(e));
            end else begin
               add_item(CMD_APPEND, 2'($urandom_range(NQ - 1)), 6'(e));
            end
         end else if (roll < 88) begin
            add_item(size_cmd(), 2'($urandom_range(3)), 6'($urandom_range(63)));
         end else begin
            add_item(2'($urandom_range(3)), 2'($urandom_range(3)), 6'($urandom_range(63)));
         end
      end
      total_items = pending_cmds.size();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while ((pending_cmds.size() != 0 || req_valid || expected_rsps.size() != 0)
             && stall_cycles < STALL_LIMIT) begin
         @(negedge clock);
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("Some tests failed");
      end else begin
         repeat (10) @(negedge clock);
         if (error_count == 0 && expected_rsps.size() == 0) begin
            $display("All tests passed");
         end else begin
            $display("Some tests failed");
         end
      end
      $finish;
   end

endmodule

// File: linked_list_queue_manager_top.f
src/llqm_pkg.sv
src/llqm_ctrl.sv
src/llqm_dp.sv
src/linked_list_queue_manager_top.sv
src/llqm_checker.sv
tb/testbench.sv
